// ===== rtl/tvbd_pkg.sv =====
// shared types, constants and round helpers for the tea variant block decryptor
`default_nettype none
package tvbd_pkg;

   localparam int unsigned ROUNDS_DEFAULT = 32;
   localparam int unsigned WORD_WIDTH     = 32;
   localparam int unsigned CSR_IDX_WIDTH  = 2;

   localparam logic [WORD_WIDTH-1:0] DELTA = 32'h9E37_79B9;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_KEY_WORD_0 = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_KEY_WORD_1 = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_KEY_WORD_2 = 2'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_KEY_WORD_3 = 2'd3;

   typedef logic [WORD_WIDTH-1:0] word_type;

   typedef struct packed {
      word_type cipher_high;
      word_type cipher_low;
      logic     last_block;
   } req_type;

   typedef struct packed {
      word_type plain_high;
      word_type plain_low;
      logic     last_out;
   } rsp_type;

   // running sum of a round, evaluated only with constant arguments
   function automatic word_type round_sum(input int unsigned round_idx);
      logic [2*WORD_WIDTH-1:0] prod;
      prod = (2*WORD_WIDTH)'(DELTA) * (2*WORD_WIDTH)'(round_idx);
      return prod[WORD_WIDTH-1:0];
   endfunction

   function automatic word_type mix(input word_type x, input word_type sum,
                                    input word_type ka, input word_type kb);
      word_type sar;
      sar = word_type'($signed(x) >>> 5);
      return ((x << 4) + ka) ^ (x + sum) ^ (sar + kb);
   endfunction

endpackage
`default_nettype wire

// ===== rtl/tea_variant_block_decrypt.sv =====
// top level: fully pipelined tea variant block decryptor, one half round per stage
//
// A block is accepted whenever start is high (busy is never raised, the
// pipeline never stalls) and its plaintext appears on rsp_data with rsp_valid
// high for one cycle once it has passed through every stage. One block can
// be accepted every cycle. Each pipeline stage performs one half round (one
// mix and subtract), so the depth is set by the round count. The receiver
// cannot stall and must take each result when rsp_valid is high. Key words
// are shared by all blocks in flight and must only be written while the
// pipeline is empty.
`default_nettype none
module tea_variant_block_decrypt
   import tvbd_pkg::*;
#(
   parameter int unsigned ROUNDS = ROUNDS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire req_type                  req_data,
   output logic                          rsp_valid,
   output rsp_type                       rsp_data,
   input  wire logic                     csr_write_enable,
   input  wire logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  wire word_type                 csr_write_data
);

   localparam int unsigned STAGES = 2 * ROUNDS;

   word_type key0_ff, key1_ff, key2_ff, key3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff <= '0;
         key1_ff <= '0;
         key2_ff <= '0;
         key3_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_KEY_WORD_0: key0_ff <= csr_write_data;
            CSR_KEY_WORD_1: key1_ff <= csr_write_data;
            CSR_KEY_WORD_2: key2_ff <= csr_write_data;
            CSR_KEY_WORD_3: key3_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   logic accept;
   assign busy   = 1'b0;
   assign accept = start && !busy;

   word_type v0_ff    [STAGES];
   word_type v1_ff    [STAGES];
   logic     last_ff  [STAGES];
   logic     valid_ff [STAGES];
   word_type v0_in    [STAGES];
   word_type v1_in    [STAGES];
   logic     last_in  [STAGES];
   logic     valid_in [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      localparam word_type SUM = round_sum(ROUNDS - 1 - s / 2);
      word_type v0_src, v1_src;
      logic     last_src, valid_src;

      if (s == 0) begin : g_head
         assign v0_src    = req_data.cipher_high;
         assign v1_src    = req_data.cipher_low;
         assign last_src  = req_data.last_block;
         assign valid_src = accept;
      end else begin : g_link
         assign v0_src    = v0_ff[s-1];
         assign v1_src    = v1_ff[s-1];
         assign last_src  = last_ff[s-1];
         assign valid_src = valid_ff[s-1];
      end

      if (s % 2 == 0) begin : g_upper
         assign v0_in[s] = v0_src;
         assign v1_in[s] = v1_src - mix(v0_src, SUM, key0_ff, key1_ff);
      end else begin : g_lower
         assign v0_in[s] = v0_src - mix(v1_src, SUM, key2_ff, key3_ff);
         assign v1_in[s] = v1_src;
      end
      assign last_in[s]  = last_src;
      assign valid_in[s] = valid_src;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_in[s];
         end
      end

      always_ff @(posedge clock) begin
         v0_ff[s]   <= v0_in[s];
         v1_ff[s]   <= v1_in[s];
         last_ff[s] <= last_in[s];
      end
   end

   assign rsp_valid           = valid_ff[STAGES-1];
   assign rsp_data.plain_high = v0_ff[STAGES-1];
   assign rsp_data.plain_low  = v1_ff[STAGES-1];
   assign rsp_data.last_out   = last_ff[STAGES-1];

`ifndef SYNTH
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_rsp_has_transfer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, STAGES))
      else $error("result without matching input transfer");

   a_last_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.last_out == $past(req_data.last_block, STAGES))
      else $error("last flag lost in pipeline");
`endif

endmodule
`default_nettype wire

// ===== test/tea_variant_block_decrypt_tb.sv =====
// self-checking testbench for the tea variant block decryptor: predicts each plaintext block
module tea_variant_block_decrypt_tb;
   import tvbd_pkg::*;

   localparam int unsigned ROUND_COUNT = ROUNDS_DEFAULT;
   localparam int unsigned CYCLE_LIMIT = 200000;

   class plaintext_scoreboard;
      word_type key_words[4];
      rsp_type  plain_expected[$];
      int       fail_count;

      function new();
         foreach (key_words[i]) key_words[i] = '0;
         fail_count = 0;
      endfunction

      function void set_key(input int unsigned idx, input word_type value);
         key_words[idx] = value;
      endfunction

      function word_type feistel_mix(input word_type x, input word_type sum,
                                     input word_type ka, input word_type kb);
         word_type sar;
         sar = {{5{x[WORD_WIDTH-1]}}, x[WORD_WIDTH-1:5]};
         return ((x << 4) + ka) ^ (x + sum) ^ (sar + kb);
      endfunction

      function rsp_type decrypt_block(input req_type blk);
         word_type v0;
         word_type v1;
         word_type sum;
         rsp_type  plain;
         v0  = blk.cipher_high;
         v1  = blk.cipher_low;
         sum = '0;
         repeat (ROUND_COUNT) sum = sum + DELTA;
         repeat (ROUND_COUNT) begin
            sum = sum - DELTA;
            v1  = v1 - feistel_mix(v0, sum, key_words[CSR_KEY_WORD_0],
                                   key_words[CSR_KEY_WORD_1]);
            v0  = v0 - feistel_mix(v1, sum, key_words[CSR_KEY_WORD_2],
                                   key_words[CSR_KEY_WORD_3]);
         end
         plain.plain_high = v0;
         plain.plain_low  = v1;
         plain.last_out   = blk.last_block;
         return plain;
      endfunction

      function void note_block(input req_type blk);
         plain_expected.push_back(decrypt_block(blk));
      endfunction

      function void check_plain(input rsp_type actual);
         rsp_type want;
         if (plain_expected.size() == 0) begin
            $display("%0t unexpected result: expected none actual %h", $time, actual);
            fail_count++;
            return;
         end
         want = plain_expected.pop_front();
         if (actual.plain_high !== want.plain_high) begin
            $display("%0t plain_high mismatch: expected %h actual %h",
                     $time, want.plain_high, actual.plain_high);
            fail_count++;
         end
         if (actual.plain_low !== want.plain_low) begin
            $display("%0t plain_low mismatch: expected %h actual %h",
                     $time, want.plain_low, actual.plain_low);
            fail_count++;
         end
         if (actual.last_out !== want.last_out) begin
            $display("%0t last_out mismatch: expected %b actual %b",
                     $time, want.last_out, actual.last_out);
            fail_count++;
         end
      endfunction

      function int pending();
         return plain_expected.size();
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   req_type                  req_data = '0;
   logic                     rsp_valid;
   rsp_type                  rsp_data;
   logic                     csr_write_enable = 1'b0;
   logic [CSR_IDX_WIDTH-1:0] csr_index = '0;
   word_type                 csr_write_data = '0;

   plaintext_scoreboard sb;
   int unsigned         cycle_count = 0;

   tea_variant_block_decrypt #(
      .ROUNDS(ROUND_COUNT)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_data        (rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tea_variant_block_decrypt regression: fail");
         $finish;
      end
   end

   // result transfer monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_plain(rsp_data);
   end

   task automatic send_block(input req_type blk);
      start    <= 1'b1;
      req_data <= blk;
      do @(posedge clock); while (busy);
      sb.note_block(blk);
   endtask

   task automatic hold_off(input int unsigned cycles);
      if (cycles != 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic drain_pipeline();
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_keys(input word_type k0, input word_type k1,
                            input word_type k2, input word_type k3);
      word_type keys[4];
      keys = '{k0, k1, k2, k3};
      for (int i = 0; i < 4; i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= CSR_IDX_WIDTH'(i);
         csr_write_data   <= keys[i];
         @(posedge clock);
         sb.set_key(i, keys[i]);
      end
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic word_type pick_word();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return 32'h8000_0000;
         3:       return 32'h7fff_ffff;
         default: return word_type'($urandom);
      endcase
   endfunction

   task automatic send_edge_blocks();
      req_type blk;
      word_type edges[6];
      edges = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000,
                32'h7fff_ffff, 32'h0000_0001, 32'h5555_aaaa};
      for (int i = 0; i < 6; i++) begin
         blk.cipher_high = edges[i];
         blk.cipher_low  = edges[5 - i];
         blk.last_block  = i[0];
         send_block(blk);
      end
      drain_pipeline();
   endtask

   task automatic random_phase(input int unsigned count, input bit with_gaps);
      req_type     blk;
      int unsigned burst_left;
      burst_left = $urandom_range(1, 24);
      for (int unsigned n = 0; n < count; n++) begin
         if (burst_left == 0) begin
            if (with_gaps) hold_off($urandom_range(0, 12));
            burst_left = $urandom_range(1, 24);
         end
         blk.cipher_high = pick_word();
         blk.cipher_low  = pick_word();
         blk.last_block  = 1'($urandom_range(0, 1));
         send_block(blk);
         burst_left--;
      end
      drain_pipeline();
   endtask

   initial begin
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset keys, all-ones keys, sign-boundary keys
      send_edge_blocks();
      load_keys('1, '1, '1, '1);
      send_edge_blocks();
      load_keys(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      send_edge_blocks();

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            1:       load_keys('0, '0, '0, '0);
            2:       load_keys('1, '1, '1, '1);
            4:       load_keys(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
            default: load_keys($urandom, $urandom, $urandom, $urandom);
         endcase
         random_phase(106, phase % 3 != 2);
      end

      if (sb.fail_count == 0) begin
         $display("tea_variant_block_decrypt regression: pass");
      end else begin
         $display("tea_variant_block_decrypt regression: fail");
      end
      $finish;
   end

endmodule
